// ----- rtl/assert_macros.svh -----
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion sampled on the rising edge, held off during reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
// implication form of the above
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	`ASSERT_AT(lbl, clk, rstn, (ante) |-> (cons))
`endif

// ----- rtl/wdft_pkg.sv -----
// package for the windowed dft bin magnitude block
// word types, state codes, register indexes and the quarter wave polynomial
package wdft_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_START = 2'd2;

	typedef struct packed {
		logic signed [15:0] sample;
		logic is_last;
	} smp_word_t;

	typedef struct packed {
		logic [15:0] magnitude;
		logic degenerate;
	} res_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_MULW,
		ST_MULS,
		ST_ACC,
		ST_CHK,
		ST_NORM,
		ST_SQA,
		ST_SQB,
		ST_SQSUM,
		ST_ROOT,
		ST_SCALE,
		ST_DCHK,
		ST_DIV,
		ST_FIN
	} state_t;

	// quarter wave sine, x in q16 over 0..1, result q15
	function automatic logic [15:0] quarter_wave(input logic [16:0] x);
		logic [63:0] xx, x2, x3, x5, y, q;
		begin
			xx = 64'(x);
			x2 = (xx * xx) >> 16;
			x3 = (x2 * xx) >> 16;
			x5 = (x3 * x2) >> 16;
			y = 64'd102944 * xx + 64'd4640 * x5 - 64'd42047 * x3;
			q = (y + 64'd65536) >> 17;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			return q[15:0];
		end
	endfunction
endpackage

// ----- rtl/windowed_dft_bin_magnitude.sv -----
// top level of the hann windowed single bin dft magnitude block
// depends on wdft_pkg and assert_macros.svh
// channel   dir  handshake             word
// smp       in   smp_valid/smp_stall   wdft_pkg::smp_word_t
// res       out  res_valid/res_stall   wdft_pkg::res_word_t
// cfg       in   cfg_we                cfg_index, cfg_data
// a sample goes through table lookup, window multiply, 16 bit serial tone multiply, sum
// the last sample adds a check step, normalize steps, squaring of both parts, their sum,
// 32 root steps, scaling and the divide steps before the word lands in the output register
// reset clears control, steps, phases and sums; no clearing pass
// a waiting result word holds the block in its final cycle until res_stall drops
`include "assert_macros.svh"
module windowed_dft_bin_magnitude #(
	parameter int SAMPLE_BITS = wdft_pkg::SAMPLE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = wdft_pkg::TABLE_ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic smp_valid,
	output logic smp_stall,
	input wdft_pkg::smp_word_t smp_word,
	output logic res_valid,
	input logic res_stall,
	output wdft_pkg::res_word_t res_word,
	input logic cfg_we,
	input logic [wdft_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [wdft_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wdft_pkg::*;

	localparam int T = TABLE_ADDR_BITS;
	localparam int QN = 2 ** (T - 2);
	localparam int SW_W = SAMPLE_BITS + 16;
	localparam int PW = SW_W + 16;
	localparam int EMAX = 49 - SAMPLE_BITS;
	localparam int NW = 33 + EMAX;

	typedef logic [15:0] qtab_t [QN+1];

	function automatic qtab_t make_qtab();
		qtab_t t;
		begin
			for (int j = 0; j <= QN; j++) begin
				t[j] = quarter_wave(17'(j << (18 - T)));
			end
			return t;
		end
	endfunction

	localparam qtab_t QTAB = make_qtab();

	function automatic logic signed [15:0] sin_val(input logic [T-1:0] idx);
		logic [1:0] quad;
		logic [T-1:0] j;
		logic [15:0] v;
		begin
			quad = idx[T-1:T-2];
			j = quad[0] ? (T'(QN) - T'(idx[T-3:0])) : T'(idx[T-3:0]);
			v = QTAB[j[T-2:0]];
			return quad[1] ? -$signed(v) : $signed(v);
		end
	endfunction

	function automatic logic signed [15:0] cos_val(input logic [T-1:0] idx);
		return sin_val(idx + T'(QN));
	endfunction

	state_t state_q, state_d;
	logic [5:0] cnt_q;
	logic last_q, degen_q, sat_q;
	logic [31:0] window_step_q, tone_start_q, window_phase_q, tone_phase_q;
	logic [30:0] tone_step_q;
	logic signed [SAMPLE_BITS-1:0] s_q;
	logic [14:0] w_q;
	logic [15:0] c_q, sn_q;
	logic signed [PW-1:0] swsh_q, acc_re_q, acc_im_q;
	logic [63:0] real_sum_q, imag_sum_q, a_q, b_q;
	logic [31:0] weight_sum_q;
	logic [5:0] sh_q;
	logic [61:0] prod_q;
	logic [62:0] v_q, res_q;
	logic [NW-1:0] n_q;
	logic [15:0] quo_q;
	logic out_valid_q;
	res_word_t out_q;

	logic [39:0] smp_ext;
	logic signed [15:0] cw;
	logic [16:0] wd;
	logic signed [SW_W-1:0] sw;
	logic signed [PW-1:0] re_sh, im_sh;
	logic [32:0] ws_sum;
	logic [62:0] bitv, rtry;
	logic [32:0] num;
	logic signed [7:0] e;
	logic [NW-1:0] dsh;
	logic fin_go;

	assign smp_stall = (state_q != ST_IDLE);
	assign res_valid = out_valid_q;
	assign res_word = out_q;

	assign smp_ext = {24'b0, smp_word.sample};
	assign cw = cos_val(window_phase_q[31 -: T]);
	assign wd = 17'd32768 - {cw[15], cw};
	assign sw = s_q * $signed({1'b0, w_q});
	assign re_sh = acc_re_q >>> 15;
	assign im_sh = acc_im_q >>> 15;
	assign ws_sum = {1'b0, weight_sum_q} + {18'b0, w_q};
	assign bitv = 63'(1) << {cnt_q[4:0], 1'b0};
	assign rtry = res_q + bitv;
	assign num = {res_q[31:0], 1'b0};
	assign e = 8'(sh_q) + 8'sd16 - 8'(SAMPLE_BITS);
	assign dsh = NW'(weight_sum_q) << cnt_q[3:0];
	assign fin_go = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (smp_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_MULW;
			ST_MULW: state_d = ST_MULS;
			ST_MULS: if (cnt_q == 6'd15) state_d = ST_ACC;
			ST_ACC: state_d = last_q ? ST_CHK : ST_IDLE;
			ST_CHK: state_d = (weight_sum_q == 32'd0) ? ST_FIN : ST_NORM;
			ST_NORM: if (a_q[63:31] == '0 && b_q[63:31] == '0) state_d = ST_SQA;
			ST_SQA: state_d = ST_SQB;
			ST_SQB: state_d = ST_SQSUM;
			ST_SQSUM: state_d = ST_ROOT;
			ST_ROOT: if (cnt_q == 6'd0) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DCHK;
			ST_DCHK: state_d = ST_DIV;
			ST_DIV: if (cnt_q == 6'd0) state_d = ST_FIN;
			ST_FIN: if (fin_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_step_q <= '0;
			tone_step_q <= '0;
			tone_start_q <= '0;
			window_phase_q <= '0;
			tone_phase_q <= '0;
			real_sum_q <= '0;
			imag_sum_q <= '0;
			weight_sum_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			last_q <= 1'b0;
			degen_q <= 1'b0;
			sat_q <= 1'b0;
			sh_q <= '0;
		end else begin
			if (out_valid_q && !res_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_STEP: window_step_q <= cfg_data;
					CFG_TONE_STEP: tone_step_q <= cfg_data[30:0];
					CFG_TONE_START: begin
						tone_start_q <= cfg_data;
						tone_phase_q <= cfg_data;
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (smp_valid) begin
						s_q <= $signed(smp_ext[SAMPLE_BITS-1:0]);
						last_q <= smp_word.is_last;
					end
				end
				ST_LOOKUP: begin
					w_q <= wd[15:1];
					c_q <= cos_val(tone_phase_q[31 -: T]);
					sn_q <= sin_val(tone_phase_q[31 -: T]);
					window_phase_q <= window_phase_q + window_step_q;
					tone_phase_q <= tone_phase_q + {1'b0, tone_step_q};
				end
				ST_MULW: begin
					swsh_q <= {{16{sw[SW_W-1]}}, sw};
					acc_re_q <= '0;
					acc_im_q <= '0;
					cnt_q <= '0;
				end
				ST_MULS: begin
					// sign bit of the multiplier weighs negative
					if (c_q[0]) begin
						acc_re_q <= (cnt_q == 6'd15) ? acc_re_q - swsh_q : acc_re_q + swsh_q;
					end
					if (sn_q[0]) begin
						acc_im_q <= (cnt_q == 6'd15) ? acc_im_q - swsh_q : acc_im_q + swsh_q;
					end
					swsh_q <= swsh_q <<< 1;
					c_q <= c_q >> 1;
					sn_q <= sn_q >> 1;
					cnt_q <= cnt_q + 6'd1;
				end
				ST_ACC: begin
					real_sum_q <= real_sum_q + {{(64-PW){re_sh[PW-1]}}, re_sh};
					imag_sum_q <= imag_sum_q - {{(64-PW){im_sh[PW-1]}}, im_sh};
					weight_sum_q <= ws_sum[32] ? 32'hFFFF_FFFF : ws_sum[31:0];
				end
				ST_CHK: begin
					degen_q <= (weight_sum_q == 32'd0);
					a_q <= real_sum_q[63] ? (~real_sum_q + 64'd1) : real_sum_q;
					b_q <= imag_sum_q[63] ? (~imag_sum_q + 64'd1) : imag_sum_q;
					sh_q <= '0;
				end
				ST_NORM: begin
					if (a_q[63:31] != '0 || b_q[63:31] != '0) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						sh_q <= sh_q + 6'd1;
					end
				end
				ST_SQA: prod_q <= a_q[30:0] * a_q[30:0];
				ST_SQB: begin
					v_q <= {1'b0, prod_q};
					prod_q <= b_q[30:0] * b_q[30:0];
				end
				ST_SQSUM: begin
					v_q <= v_q + {1'b0, prod_q};
					res_q <= '0;
					cnt_q <= 6'd31;
				end
				ST_ROOT: begin
					if (v_q >= rtry) begin
						v_q <= v_q - rtry;
						res_q <= (res_q >> 1) + bitv;
					end else begin
						res_q <= res_q >> 1;
					end
					cnt_q <= cnt_q - 6'd1;
				end
				ST_SCALE: begin
					n_q <= e[7] ? NW'(num >> 7'(-e)) : (NW'(num) << e[6:0]);
				end
				ST_DCHK: begin
					sat_q <= (n_q >= (NW'(weight_sum_q) << 16));
					quo_q <= '0;
					cnt_q <= 6'd15;
				end
				ST_DIV: begin
					if (n_q >= dsh) begin
						n_q <= n_q - dsh;
						quo_q[cnt_q[3:0]] <= 1'b1;
					end
					cnt_q <= cnt_q - 6'd1;
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						out_q.degenerate <= degen_q;
						out_q.magnitude <= degen_q ? 16'd0 : (sat_q ? 16'hFFFF : quo_q);
						window_phase_q <= '0;
						tone_phase_q <= tone_start_q;
						real_sum_q <= '0;
						imag_sum_q <= '0;
						weight_sum_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	`ASSERT_IMP(a_fin_holds, clk, arst_n, state_q == ST_FIN && out_valid_q && res_stall,
		##1 state_q == ST_FIN)
	`ASSERT_IMP(a_degen_zero, clk, arst_n, res_valid && res_word.degenerate,
		res_word.magnitude == 16'd0)
	`ASSERT_IMP(a_accept_lookup, clk, arst_n, smp_valid && !smp_stall, ##1 state_q == ST_LOOKUP)
endmodule
